// ===== rtl/core/utf8d_pkg.sv =====
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned MTdataW = ((CpW + 7) / 8) * 8;

  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;

  // One decoded byte's worth of output.  The first count-1 results are
  // always the replacement character; the final one carries last_cp.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [CpW-1:0]    last_cp;
  } burst_t;

endpackage

// ===== rtl/core/utf8d_decode.sv =====
module utf8d_decode (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  logic [utf8d_pkg::ByteW-1:0]   data_byte,
  input  logic                          end_of_text,
  output utf8d_pkg::burst_t             burst
);

  logic [utf8d_pkg::CpW-1:0] partial_value, partial_value_next;
  logic [1:0]                bytes_needed, bytes_needed_next;
  logic [1:0]                bytes_held, bytes_held_next;

  always_comb begin
    logic                         is_cont;
    logic [utf8d_pkg::CountW-1:0] rep;
    logic [utf8d_pkg::CpW-1:0]    lead_bits;
    logic [1:0]                   lead_need;

    is_cont   = (data_byte[7:6] == 2'b10);
    rep       = '0;
    lead_bits = '0;
    lead_need = 2'd0;

    partial_value_next = partial_value;
    bytes_needed_next  = bytes_needed;
    bytes_held_next    = bytes_held;
    burst.count        = '0;
    burst.last_cp      = utf8d_pkg::Replacement;

    if ((bytes_needed != 2'd0) && is_cont) begin
      partial_value_next = {partial_value[utf8d_pkg::CpW-7:0], data_byte[5:0]};
      bytes_needed_next  = bytes_needed - 2'd1;
      if (bytes_needed == 2'd1) begin
        burst.count   = 3'd1;
        burst.last_cp = {partial_value[utf8d_pkg::CpW-7:0], data_byte[5:0]};
      end else if (end_of_text) begin
        burst.count = {1'b0, bytes_held} + 3'd1;
      end else begin
        bytes_held_next = bytes_held + 2'd1;
      end
    end else begin
      // A broken sequence flushes one replacement per held byte, then the
      // new byte is taken as a lead in the same beat.
      if (bytes_needed != 2'd0) begin
        rep = {1'b0, bytes_held};
      end
      partial_value_next = '0;
      bytes_needed_next  = 2'd0;
      bytes_held_next    = 2'd0;
      if (data_byte[7] == 1'b0) begin
        burst.count   = rep + 3'd1;
        burst.last_cp = {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, data_byte};
      end else begin
        if (data_byte[7:5] == 3'b110) begin
          lead_bits = {16'd0, data_byte[4:0]};
          lead_need = 2'd1;
        end else if (data_byte[7:4] == 4'b1110) begin
          lead_bits = {17'd0, data_byte[3:0]};
          lead_need = 2'd2;
        end else if (data_byte[7:3] == 5'b11110) begin
          lead_bits = {18'd0, data_byte[2:0]};
          lead_need = 2'd3;
        end
        if (lead_need == 2'd0 || end_of_text) begin
          burst.count = rep + 3'd1;
        end else begin
          burst.count        = rep;
          partial_value_next = lead_bits;
          bytes_needed_next  = lead_need;
          bytes_held_next    = 2'd1;
        end
      end
    end

    if (end_of_text) begin
      partial_value_next = '0;
      bytes_needed_next  = 2'd0;
      bytes_held_next    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value <= '0;
      bytes_needed  <= 2'd0;
      bytes_held    <= 2'd0;
    end else if (fire) begin
      partial_value <= partial_value_next;
      bytes_needed  <= bytes_needed_next;
      bytes_held    <= bytes_held_next;
    end
  end

endmodule

// ===== rtl/core/utf8d_emit.sv =====
module utf8d_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  utf8d_pkg::burst_t             burst,
  output logic                          can_load,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utf8d_pkg::CpW-1:0]     code_point,
  output logic                          run_last
);

  logic [utf8d_pkg::CountW-1:0] remaining;
  logic [utf8d_pkg::CpW-1:0]    last_cp;
  logic                         last_taken;

  assign run_last   = (remaining == 3'd1);
  assign code_point = run_last ? last_cp : utf8d_pkg::Replacement;
  assign last_taken = out_valid && out_ready && run_last;
  assign can_load   = !out_valid || last_taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (load && burst.count != '0) begin
      out_valid <= 1'b1;
      remaining <= burst.count;
    end else if (last_taken) begin
      out_valid <= 1'b0;
      remaining <= '0;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && burst.count != '0) begin
      last_cp <= burst.last_cp;
    end
  end

endmodule

// ===== rtl/core/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder.
// The slave channel takes one raw byte per beat, with tlast on the final byte
// of a text. The master channel gives decoded code points, one per beat, with
// tlast on the final result caused by a given input byte.
// Each accepted byte is decoded in the cycle it is taken and its results are
// registered; the first result appears in the cycle after acceptance.
// A byte that completes a character or is plain ASCII gives one result, so
// valid text flows at one byte per cycle while the receiver takes every result.
// A byte that only opens or extends a sequence gives none. A broken or truncated
// sequence gives up to four results, one replacement character per held byte,
// which occupy the output register for that many beats; the slave side is held
// off until the final result of the burst is being taken.
// The next byte is accepted in the same cycle as the last result of the
// previous one, so the output register never leaves a bubble.
// Reset clears the open sequence and drops any pending results. When the
// receiver stalls, the current result holds and the input stalls behind it.
module utf8_stream_decoder_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [utf8d_pkg::ByteW-1:0]        s_axis_tdata,  // [7:0] data_byte
  input  logic                               s_axis_tlast,  // end_of_text
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [utf8d_pkg::MTdataW-1:0]      m_axis_tdata,  // [20:0] code_point
  output logic                               m_axis_tlast   // run_last
);

  utf8d_pkg::burst_t          burst;
  logic                       fire;
  logic                       can_load;
  logic [utf8d_pkg::CpW-1:0]  code_point;

  assign s_axis_tready = can_load;
  assign fire          = s_axis_tvalid && s_axis_tready;

  utf8d_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (s_axis_tdata),
    .end_of_text (s_axis_tlast),
    .burst       (burst)
  );

  utf8d_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (fire),
    .burst      (burst),
    .can_load   (can_load),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .code_point (code_point),
    .run_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {{(utf8d_pkg::MTdataW-utf8d_pkg::CpW){1'b0}}, code_point};

endmodule

// ===== rtl/core/utf8d_checker.sv =====
module utf8d_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [utf8d_pkg::MTdataW-1:0]  m_axis_tdata,
  input logic                           m_axis_tlast
);

  // A stalled result beat must hold.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // Only the final beat of a burst may carry anything but the replacement.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata == utf8d_pkg::Replacement)
    else $error("non-final beat is not a replacement character");

  // With nothing waiting at the output, the input must be open.
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A beat stalled mid-burst keeps the input closed.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted while a burst is unfinished");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_utf8d_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
